// ===== sv/convection_flux_stencil_assert.svh =====
// Assertion helpers for the stencil control module (cfs_ctrl).
// Both expect clk and rst_n in scope.
`ifndef CONVECTION_FLUX_STENCIL_ASSERT_SVH
`define CONVECTION_FLUX_STENCIL_ASSERT_SVH

// same-cycle implication
`define CFS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stencil check failed");

// next-cycle implication
`define CFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stencil check failed");

`endif

// ===== sv/cfs_pkg.sv =====
package cfs_pkg;

    localparam int PHI_W  = 24;
    localparam int VEL_W  = 16;
    localparam int FLUX_W = 32;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 3;
    localparam int SCH_W  = 2;
    localparam int SIZE_W = 9;
    localparam int COEF_W = 16;

    // datapath widths
    localparam int DS_W   = 29;            // stencil differences
    localparam int HW_W   = 34;            // coefficient times velocity
    localparam int PROD_W = HW_W + DS_W;
    localparam int ACC_W  = 64;
    localparam int STEP_W = 4;

    localparam int NB_COUNT  = 8;
    localparam int MUL_STEPS = 9;
    localparam int MIN_SIZE  = 3;

    localparam logic [SCH_W-1:0]  SCHEME_RST = 2'd1;
    localparam logic [COEF_W-1:0] HALF_INV_RST = 16'd8192;
    localparam logic [SIZE_W-1:0] SIZE_RST = 9'd65;

    localparam logic signed [ACC_W-1:0] RND_HALF_20 = 64'sd524288;
    localparam logic signed [ACC_W-1:0] RND_HALF_21 = 64'sd1048576;
    localparam logic signed [ACC_W-1:0] FLUX_MAX_EXT = 64'sd2147483647;
    localparam logic signed [ACC_W-1:0] FLUX_MIN_EXT = -64'sd2147483648;

    typedef enum logic [IDX_W-1:0] {
        REG_SCHEME      = 3'd0,
        REG_HALF_INV_DX = 3'd1,
        REG_HALF_INV_DY = 3'd2,
        REG_COLS        = 3'd3,
        REG_ROWS        = 3'd4
    } cfg_reg_t;

    typedef enum logic [SCH_W-1:0] {
        SCH_UPWIND1 = 2'd0,
        SCH_CENTRAL = 2'd1,
        SCH_UPWIND2 = 2'd2
    } scheme_t;

    typedef enum logic [2:0] {
        NB_C, NB_E1, NB_W1, NB_N1, NB_S1, NB_W2, NB_N2, NB_S2
    } nb_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_CLASS, ST_READ, ST_PREP, ST_MUL, ST_EMIT
    } cfs_state_t;

    typedef struct packed {
        logic signed [PHI_W-1:0] phi_sample;
        logic signed [VEL_W-1:0] x_velocity;
        logic signed [VEL_W-1:0] y_velocity;
        logic                    pad;
    } in_item_t;

    typedef struct packed {
        logic signed [FLUX_W-1:0] flux;
        logic                     is_boundary;
        logic                     last_point;
    } out_item_t;

    typedef struct packed {
        logic signed [PHI_W-1:0] p;
        logic signed [VEL_W-1:0] u;
        logic signed [VEL_W-1:0] v;
    } hist_t;

    typedef struct packed {
        logic              take;
        logic              div_step;
        logic              rd_en;
        nb_sel_t           rd_sel;
        logic              prep;
        logic              mul_en;
        logic [STEP_W-1:0] mul_step;
        logic              emit;
    } dp_cmd_t;

    typedef struct packed {
        logic emits;
        logic div_last;
        logic boundary;
        logic out_free;
    } dp_status_t;

endpackage

// ===== sv/convection_flux_stencil.sv =====
// Convection flux stencil: grid points arrive in raster order (rows slow, columns fast) and
// each point's flux u*dphi/dx + v*dphi/dy comes out once the point two rows further on has
// arrived; pad requests then flush the last two rows, and last_point marks the end of a grid.
// Boundary points return zero flux with is_boundary set. One request is worked at a time: a
// request that yields no result is taken without leaving the idle state, a boundary result
// skips the neighbor reads and the multiplier, and the time an interior result takes is set
// by the bit-serial row/column divider, the single read port of the 4*MAX_COLS+1 entry
// history memory (eight neighbor reads) and one shared multiplier used over nine steps.
// A finished result waits in an output register while the next request is taken.
// Configuration is written through cfg_we/cfg_index/cfg_wdata.
module convection_flux_stencil #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  cfs_pkg::in_item_t         in_item,
    output logic                      out_valid,
    input  logic                      out_ready,
    output cfs_pkg::out_item_t        out_item,
    input  logic                      cfg_we,
    input  logic [cfs_pkg::IDX_W-1:0] cfg_index,
    input  logic [cfs_pkg::CFG_W-1:0] cfg_wdata
);
    import cfs_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    cfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    cfs_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_item  (out_item),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== sv/cfs_ctrl.sv =====
module cfs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cfs_pkg::dp_status_t status,
    output cfs_pkg::dp_cmd_t    cmd
);
    import cfs_pkg::*;

    cfs_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
                if (in_valid && status.emits)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = ST_CLASS;
            end
            ST_CLASS:
            begin
                step_next  = '0;
                state_next = status.boundary ? ST_EMIT : ST_READ;
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = nb_sel_t'(step_reg[2:0]);
                if (step_reg == STEP_W'(NB_COUNT - 1))
                begin
                    step_next  = '0;
                    state_next = ST_PREP;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                step_next  = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = step_reg;
                if (step_reg == STEP_W'(MUL_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_EMIT;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

`include "convection_flux_stencil_assert.svh"

    `CFS_ASSERT_NEXT(a_take_starts_div, in_valid && in_ready && status.emits, state_reg == ST_DIV)
    `CFS_ASSERT_IMP(a_class_after_div, state_reg == ST_CLASS, $past(state_reg) == ST_DIV)
    `CFS_ASSERT_NEXT(a_emit_frees_input, cmd.emit, in_ready)
    `CFS_ASSERT_NEXT(a_prep_to_mul, state_reg == ST_PREP, state_reg == ST_MUL && step_reg == '0)

endmodule

// ===== sv/cfs_dp.sv =====
module cfs_dp #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfs_pkg::in_item_t             in_item,
    input  logic                          cfg_we,
    input  logic [cfs_pkg::IDX_W-1:0]     cfg_index,
    input  logic [cfs_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          out_ready,
    output logic                          out_valid,
    output cfs_pkg::out_item_t            out_item,
    input  cfs_pkg::dp_cmd_t              cmd,
    output cfs_pkg::dp_status_t           status
);
    import cfs_pkg::*;

    localparam int DEPTH   = 4 * MAX_COLS + 1;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int KW      = ADDR_W + 1;
    localparam int COL_W   = $clog2(MAX_COLS + 1);
    localparam int ROW_W   = $clog2(MAX_ROWS + 1);
    localparam int CNT_W   = $clog2(MAX_ROWS * MAX_COLS);
    localparam int DCNT_W  = $clog2(CNT_W);
    localparam int AREA_W  = ROW_W + COL_W;

    // configuration
    logic [SCH_W-1:0]  scheme_reg;
    logic [COEF_W-1:0] hx_reg, hy_reg;
    logic [SIZE_W-1:0] cols_cfg_reg, rows_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scheme_reg   <= SCHEME_RST;
            hx_reg       <= HALF_INV_RST;
            hy_reg       <= HALF_INV_RST;
            cols_cfg_reg <= SIZE_RST;
            rows_cfg_reg <= SIZE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SCHEME:      scheme_reg   <= cfg_wdata[SCH_W-1:0];
                REG_HALF_INV_DX: hx_reg       <= cfg_wdata[COEF_W-1:0];
                REG_HALF_INV_DY: hy_reg       <= cfg_wdata[COEF_W-1:0];
                REG_COLS:        cols_cfg_reg <= cfg_wdata[SIZE_W-1:0];
                REG_ROWS:        rows_cfg_reg <= cfg_wdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    logic [COL_W-1:0] cols_c;
    logic [ROW_W-1:0] rows_c;

    always_comb
    begin
        if (cols_cfg_reg < SIZE_W'(MIN_SIZE))
            cols_c = COL_W'(MIN_SIZE);
        else if (32'(cols_cfg_reg) > MAX_COLS)
            cols_c = COL_W'(MAX_COLS);
        else
            cols_c = COL_W'(cols_cfg_reg);
        if (rows_cfg_reg < SIZE_W'(MIN_SIZE))
            rows_c = ROW_W'(MIN_SIZE);
        else if (32'(rows_cfg_reg) > MAX_ROWS)
            rows_c = ROW_W'(MAX_ROWS);
        else
            rows_c = ROW_W'(rows_cfg_reg);
    end

    // input position and history pointer
    logic [COL_W-1:0]  in_col_reg;
    logic [ROW_W-1:0]  in_row_reg;
    logic [CNT_W-1:0]  out_cnt_reg;
    logic [ADDR_W-1:0] wr_pos_reg, wr_next;
    logic [COL_W:0]    col_inc;
    logic              flushing, kept, take, last;
    logic [AREA_W-1:0] area;
    hist_t             wr_word;

    assign flushing = (in_row_reg >= rows_c);
    assign kept     = !in_item.pad || flushing;
    assign take     = cmd.take && kept;
    assign wr_next  = (wr_pos_reg == ADDR_W'(DEPTH - 1)) ? '0 : wr_pos_reg + 1'b1;
    assign col_inc  = {1'b0, in_col_reg} + 1'b1;
    assign area     = AREA_W'(rows_c) * AREA_W'(cols_c);
    assign last     = (AREA_W'(out_cnt_reg) + 1'b1) >= area;

    // flush items push zeros
    always_comb
    begin
        wr_word = '0;
        if (!flushing)
        begin
            wr_word.p = in_item.phi_sample;
            wr_word.u = in_item.x_velocity;
            wr_word.v = in_item.y_velocity;
        end
    end

    assign status.emits = kept && (flushing || in_row_reg >= ROW_W'(2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_cnt_reg <= '0;
            wr_pos_reg  <= '0;
        end
        else if (cmd.emit)
        begin
            if (last)
            begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_cnt_reg <= '0;
            end
            else
                out_cnt_reg <= out_cnt_reg + 1'b1;
        end
        else if (take)
        begin
            wr_pos_reg <= wr_next;
            if (!flushing)
            begin
                if (col_inc >= {1'b0, cols_c})
                begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + 1'b1;
                end
                else
                    in_col_reg <= col_inc[COL_W-1:0];
            end
        end
    end

    // row/column of the output point: restoring divide, one bit per cycle
    logic [CNT_W-1:0]  quo_reg;
    logic [COL_W-1:0]  rem_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [COL_W:0]    rem_sh;
    logic              rem_ge;

    assign rem_sh = {rem_reg, quo_reg[CNT_W-1]};
    assign rem_ge = rem_sh >= {1'b0, cols_c};
    assign status.div_last = (dcnt_reg == DCNT_W'(CNT_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dcnt_reg <= '0;
        else if (take)
            dcnt_reg <= '0;
        else if (cmd.div_step)
            dcnt_reg <= dcnt_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            quo_reg <= out_cnt_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? COL_W'(rem_sh - {1'b0, cols_c}) : rem_sh[COL_W-1:0];
            quo_reg <= {quo_reg[CNT_W-2:0], rem_ge};
        end
    end

    logic boundary, near_edge;

    always_comb
    begin
        boundary  = (quo_reg == '0) || (32'(quo_reg) >= 32'(rows_c) - 1)
                 || (rem_reg == '0) || (32'(rem_reg) >= 32'(cols_c) - 1);
        near_edge = (32'(quo_reg) == 1) || (32'(quo_reg) == 32'(rows_c) - 2)
                 || (32'(rem_reg) == 1) || (32'(rem_reg) == 32'(cols_c) - 2);
    end

    assign status.boundary = boundary;

    // history store and neighbor fetch
    hist_t                   mem [DEPTH];
    logic [KW-1:0]           kc, back, wr_ext;
    logic [ADDR_W-1:0]       rd_addr;
    logic signed [PHI_W-1:0] cp_reg, e1_reg, w1_reg, n1_reg, s1_reg;
    logic signed [PHI_W-1:0] w2_reg, n2_reg, s2_reg, e2_reg;
    logic signed [VEL_W-1:0] cu_reg, cv_reg;

    assign kc     = KW'(cols_c);
    assign wr_ext = {1'b0, wr_pos_reg};

    always_comb
    begin
        unique case (cmd.rd_sel)
            NB_C:    back = kc << 1;
            NB_E1:   back = kc;
            NB_W1:   back = (kc << 1) + kc;
            NB_N1:   back = (kc << 1) - 1'b1;
            NB_S1:   back = (kc << 1) + 1'b1;
            NB_W2:   back = kc << 2;
            NB_N2:   back = (kc << 1) - KW'(2);
            NB_S2:   back = (kc << 1) + KW'(2);
            default: back = kc;
        endcase
        if (wr_ext >= back)
            rd_addr = ADDR_W'(wr_ext - back);
        else
            rd_addr = ADDR_W'(wr_ext + KW'(DEPTH) - back);
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mem[wr_next] <= wr_word;
            e2_reg       <= wr_word.p;
        end
        if (cmd.rd_en)
        begin
            unique case (cmd.rd_sel)
                NB_C:
                begin
                    cp_reg <= mem[rd_addr].p;
                    cu_reg <= mem[rd_addr].u;
                    cv_reg <= mem[rd_addr].v;
                end
                NB_E1:   e1_reg <= mem[rd_addr].p;
                NB_W1:   w1_reg <= mem[rd_addr].p;
                NB_N1:   n1_reg <= mem[rd_addr].p;
                NB_S1:   s1_reg <= mem[rd_addr].p;
                NB_W2:   w2_reg <= mem[rd_addr].p;
                NB_N2:   n2_reg <= mem[rd_addr].p;
                NB_S2:   s2_reg <= mem[rd_addr].p;
                default: ;
            endcase
        end
    end

    // stencil differences: flux term is w*D + |w|*S per direction
    logic signed [DS_W-1:0] p_x, e1_x, w1_x, n1_x, s1_x, e2_x, w2_x, n2_x, s2_x;
    logic signed [DS_W-1:0] dx_c, sx_c, dy_c, sy_c;
    logic signed [DS_W-1:0] dx_reg, sx_reg, dy_reg, sy_reg;
    logic                   up1, up2, sh21_reg;

    always_comb
    begin
        p_x  = DS_W'(cp_reg);
        e1_x = DS_W'(e1_reg);
        w1_x = DS_W'(w1_reg);
        n1_x = DS_W'(n1_reg);
        s1_x = DS_W'(s1_reg);
        e2_x = DS_W'(e2_reg);
        w2_x = DS_W'(w2_reg);
        n2_x = DS_W'(n2_reg);
        s2_x = DS_W'(s2_reg);
        up1  = (scheme_reg == SCH_UPWIND1);
        up2  = (scheme_reg == SCH_UPWIND2) && !near_edge;
        if (up2)
        begin
            dx_c = (e1_x <<< 2) - e2_x - (w1_x <<< 2) + w2_x;
            sx_c = (p_x <<< 2) + (p_x <<< 1) - (w1_x <<< 2) + w2_x - (e1_x <<< 2) + e2_x;
            dy_c = (n1_x <<< 2) - n2_x - (s1_x <<< 2) + s2_x;
            sy_c = (p_x <<< 2) + (p_x <<< 1) - (s1_x <<< 2) + s2_x - (n1_x <<< 2) + n2_x;
        end
        else
        begin
            dx_c = e1_x - w1_x;
            dy_c = n1_x - s1_x;
            sx_c = up1 ? (p_x <<< 1) - e1_x - w1_x : '0;
            sy_c = up1 ? (p_x <<< 1) - n1_x - s1_x : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            dx_reg   <= dx_c;
            sx_reg   <= sx_c;
            dy_reg   <= dy_c;
            sy_reg   <= sy_c;
            sh21_reg <= up2;
        end
    end

    // shared multiplier, one product per step
    logic signed [VEL_W:0]   ua, va;
    logic signed [HW_W-1:0]  mul_a, hu_reg, ha_reg, hx_ext, hy_ext;
    logic signed [DS_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    assign ua     = cu_reg[VEL_W-1] ? -((VEL_W+1)'(cu_reg)) : (VEL_W+1)'(cu_reg);
    assign va     = cv_reg[VEL_W-1] ? -((VEL_W+1)'(cv_reg)) : (VEL_W+1)'(cv_reg);
    assign hx_ext = HW_W'($signed({1'b0, hx_reg}));
    assign hy_ext = HW_W'($signed({1'b0, hy_reg}));

    always_comb
    begin
        case (cmd.mul_step)
            4'd0:    begin mul_a = hx_ext; mul_b = DS_W'(cu_reg); end
            4'd1:    begin mul_a = hx_ext; mul_b = DS_W'(ua);     end
            4'd2:    begin mul_a = hu_reg; mul_b = dx_reg;        end
            4'd3:    begin mul_a = ha_reg; mul_b = sx_reg;        end
            4'd4:    begin mul_a = hy_ext; mul_b = DS_W'(cv_reg); end
            4'd5:    begin mul_a = hy_ext; mul_b = DS_W'(va);     end
            4'd6:    begin mul_a = hu_reg; mul_b = dy_reg;        end
            4'd7:    begin mul_a = ha_reg; mul_b = sy_reg;        end
            default: begin mul_a = ha_reg; mul_b = sy_reg;        end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
            case (cmd.mul_step)
                4'd1, 4'd5: hu_reg  <= HW_W'(prod_reg);
                4'd2, 4'd6: ha_reg  <= HW_W'(prod_reg);
                4'd3:       acc_reg <= ACC_W'(prod_reg);
                4'd4, 4'd7, 4'd8:
                            acc_reg <= acc_reg + ACC_W'(prod_reg);
                default: ;
            endcase
        end
    end

    // round half up, then clip to 32 bits
    logic signed [ACC_W-1:0]  acc_sum, acc_rnd;
    logic signed [FLUX_W-1:0] flux_sat;

    always_comb
    begin
        acc_sum = acc_reg + (sh21_reg ? RND_HALF_21 : RND_HALF_20);
        acc_rnd = sh21_reg ? (acc_sum >>> 21) : (acc_sum >>> 20);
        if (acc_rnd > FLUX_MAX_EXT)
            flux_sat = FLUX_W'(FLUX_MAX_EXT);
        else if (acc_rnd < FLUX_MIN_EXT)
            flux_sat = FLUX_W'(FLUX_MIN_EXT);
        else
            flux_sat = FLUX_W'(acc_rnd);
    end

    // result register
    logic      out_valid_reg;
    out_item_t out_item_reg;

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_item        = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_item_reg.flux        <= boundary ? '0 : flux_sat;
            out_item_reg.is_boundary <= boundary;
            out_item_reg.last_point  <= last;
        end
    end

endmodule

// ===== dv/convection_flux_stencil_check.sv =====
module convection_flux_stencil_check (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  cfs_pkg::in_item_t         in_item,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  cfs_pkg::out_item_t        out_item,
    input  logic                      cfg_we,
    input  logic [cfs_pkg::IDX_W-1:0] cfg_index,
    input  logic [cfs_pkg::CFG_W-1:0] cfg_wdata,
    output int                        errors,
    output int                        pending,
    output int                        checked,
    output int                        interior_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import cfs_pkg::*;

    localparam int GRID_MAX = 256;
    localparam int DEPTH    = 4 * GRID_MAX + 1;

    longint     phi_hist [DEPTH];
    longint     u_hist   [DEPTH];
    longint     v_hist   [DEPTH];
    int         wr_pos;
    int         col_in;
    int         row_in;
    int         points_out;

    logic [SCH_W-1:0]  sch;
    logic [COEF_W-1:0] hx_q;
    logic [COEF_W-1:0] hy_q;
    logic [SIZE_W-1:0] cols_q;
    logic [SIZE_W-1:0] rows_q;

    out_item_t  flux_due [$];

    function automatic int clamp_dim(logic [SIZE_W-1:0] x);
        if (x < MIN_SIZE) return MIN_SIZE;
        if (x > GRID_MAX) return GRID_MAX;
        return int'(x);
    endfunction

    function automatic int back_idx(int back);
        return (wr_pos + DEPTH - (back % DEPTH)) % DEPTH;
    endfunction

    function automatic longint mag(longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic logic [FLUX_W-1:0] interior_flux(int r, int c, int rows, int cols);
        int     base;
        longint p, u, v, e1, w1, n1, s1, e2, w2, n2, s2, tx, ty, acc;
        int     sh;
        bit     near_edge;
        base = 2 * cols;
        p  = phi_hist[back_idx(base)];
        u  = u_hist[back_idx(base)];
        v  = v_hist[back_idx(base)];
        e1 = phi_hist[back_idx(base - cols)];
        w1 = phi_hist[back_idx(base + cols)];
        n1 = phi_hist[back_idx(base - 1)];
        s1 = phi_hist[back_idx(base + 1)];
        sh = 20;
        near_edge = (r == 1 || r == rows - 2 || c == 1 || c == cols - 2);
        if (sch == SCH_UPWIND1) begin
            tx = u * (e1 - w1) - mag(u) * (e1 - 2 * p + w1);
            ty = v * (n1 - s1) - mag(v) * (n1 - 2 * p + s1);
        end
        else if (sch == SCH_UPWIND2 && !near_edge) begin
            e2 = phi_hist[back_idx(0)];
            w2 = phi_hist[back_idx(base + 2 * cols)];
            n2 = phi_hist[back_idx(base - 2)];
            s2 = phi_hist[back_idx(base + 2)];
            tx = u * (4 * e1 - e2 - 4 * w1 + w2) + mag(u) * (6 * p - 4 * w1 + w2 - 4 * e1 + e2);
            ty = v * (4 * n1 - n2 - 4 * s1 + s2) + mag(v) * (6 * p - 4 * s1 + s2 - 4 * n1 + n2);
            sh = 21;
        end
        else begin
            // central, the spare scheme code, and second-order upwind near an edge
            tx = u * (e1 - w1);
            ty = v * (n1 - s1);
        end
        acc = tx * longint'(hx_q) + ty * longint'(hy_q);
        acc = (acc + (64'sd1 <<< (sh - 1))) >>> sh;
        if (acc > FLUX_MAX_EXT) acc = FLUX_MAX_EXT;
        if (acc < FLUX_MIN_EXT) acc = FLUX_MIN_EXT;
        return acc[FLUX_W-1:0];
    endfunction

    task automatic take_point(input in_item_t it);
        int        cols, rows, row_now, r, c;
        bit        flushing;
        out_item_t res;
        cols = clamp_dim(cols_q);
        rows = clamp_dim(rows_q);
        flushing = row_in >= rows;
        if (!flushing && it.pad)
            return;
        wr_pos = (wr_pos + 1) % DEPTH;
        phi_hist[wr_pos] = flushing ? 0 : longint'(it.phi_sample);
        u_hist[wr_pos]   = flushing ? 0 : longint'(it.x_velocity);
        v_hist[wr_pos]   = flushing ? 0 : longint'(it.y_velocity);
        if (!flushing) begin
            row_now = row_in;
            col_in++;
            if (col_in >= cols) begin
                col_in = 0;
                row_in++;
            end
            if (row_now < 2)
                return;
        end
        r = points_out / cols;
        c = points_out % cols;
        res.is_boundary = (r == 0 || r >= rows - 1 || c == 0 || c >= cols - 1);
        res.flux = res.is_boundary ? '0 : interior_flux(r, c, rows, cols);
        res.last_point = (points_out + 1) >= rows * cols;
        flux_due.push_back(res);
        points_out++;
        if (res.last_point) begin
            col_in = 0;
            row_in = 0;
            points_out = 0;
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: %s mismatch: got %0d, want %0d", $time, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n) begin
            foreach (phi_hist[k]) begin
                phi_hist[k] = 0;
                u_hist[k] = 0;
                v_hist[k] = 0;
            end
            wr_pos = 0;
            col_in = 0;
            row_in = 0;
            points_out = 0;
            sch = SCHEME_RST;
            hx_q = HALF_INV_RST;
            hy_q = HALF_INV_RST;
            cols_q = SIZE_RST;
            rows_q = SIZE_RST;
            flux_due.delete();
            errors = 0;
            checked = 0;
            interior_seen = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_SCHEME:      sch = cfg_wdata[SCH_W-1:0];
                    REG_HALF_INV_DX: hx_q = cfg_wdata;
                    REG_HALF_INV_DY: hy_q = cfg_wdata;
                    REG_COLS:        cols_q = cfg_wdata[SIZE_W-1:0];
                    REG_ROWS:        rows_q = cfg_wdata[SIZE_W-1:0];
                    default: ;
                endcase
            end
            // a result leaves only after its request has been taken, so compare first
            if (out_valid && out_ready) begin
                if (flux_due.size() == 0) begin
                    $display("%0t: result with none expected", $time);
                    errors++;
                end
                else begin
                    want = flux_due.pop_front();
                    checked++;
                    if (!want.is_boundary)
                        interior_seen++;
                    if (out_item.flux !== want.flux)
                        report_mismatch("flux", out_item.flux, want.flux);
                    if (out_item.is_boundary !== want.is_boundary)
                        report_mismatch("is_boundary", out_item.is_boundary, want.is_boundary);
                    if (out_item.last_point !== want.last_point)
                        report_mismatch("last_point", out_item.last_point, want.last_point);
                end
            end
            if (in_valid && in_ready)
                take_point(in_item);
        end
        pending = flux_due.size();
    end

endmodule

// ===== dv/convection_flux_stencil_test.sv =====
module convection_flux_stencil_test;
    timeunit 1ns;
    timeprecision 1ps;
    import cfs_pkg::*;

    localparam logic [SCH_W-1:0] SCH_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_WAIT  = 60;
    localparam int HOLD_CYCLES = 800;
    localparam int IN_W        = $bits(in_item_t);
    localparam int RANDOM_REQS = 460;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    in_item_t           in_item;
    logic               out_valid;
    logic               out_ready;
    out_item_t          out_item;
    logic               cfg_we;
    logic [IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]   cfg_wdata;

    int  errors, pending, checked, interior_seen;
    int  cycles;
    int  grids;
    int  sent;
    bit  calm;
    bit  hold_req;

    convection_flux_stencil u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    convection_flux_stencil_check u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_item       (in_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_item      (out_item),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .errors        (errors),
        .pending       (pending),
        .checked       (checked),
        .interior_seen (interior_seen)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        calm = 1'b0;
        hold_req = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int gap_draw();
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int stall;
        @(negedge clk);
        forever begin
            stall = gap_draw();
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input in_item_t it);
        int gap;
        gap = gap_draw();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        sent++;
        if ($urandom_range(0, 63) == 0)
            calm = ~calm;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    function automatic logic [PHI_W-1:0] pick_phi(int style);
        case (style)
            0: return {1'b1, {(PHI_W-1){1'b0}}};
            1: return {1'b0, {(PHI_W-1){1'b1}}};
            2: return $urandom_range(0, 1) ? {1'b1, {(PHI_W-1){1'b0}}} : {1'b0, {(PHI_W-1){1'b1}}};
            3: return PHI_W'($urandom_range(0, 511) - 256);
            default: return PHI_W'($urandom());
        endcase
    endfunction

    function automatic logic [VEL_W-1:0] pick_vel(int style);
        case (style)
            0: return {1'b1, {(VEL_W-1){1'b0}}};
            1: return {1'b0, {(VEL_W-1){1'b1}}};
            2: return $urandom_range(0, 1) ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
            3: return '0;
            default: return VEL_W'($urandom());
        endcase
    endfunction

    // one grid: drain, configure, then the points, an occasional stray pad (ignored), then the flush
    task automatic run_grid(input logic [SCH_W-1:0] sch, input int hx, input int hy,
                            input int cols_w, input int rows_w, input int style);
        in_item_t it;
        int cols, rows;
        wait_drained();
        write_reg(REG_SCHEME, int'(sch));
        write_reg(REG_HALF_INV_DX, hx);
        write_reg(REG_HALF_INV_DY, hy);
        write_reg(REG_COLS, cols_w);
        write_reg(REG_ROWS, rows_w);
        cols = cols_w[SIZE_W-1:0] < MIN_SIZE ? MIN_SIZE : (cols_w[SIZE_W-1:0] > 256 ? 256 : cols_w[SIZE_W-1:0]);
        rows = rows_w[SIZE_W-1:0] < MIN_SIZE ? MIN_SIZE : (rows_w[SIZE_W-1:0] > 256 ? 256 : rows_w[SIZE_W-1:0]);
        for (int k = 0; k < rows * cols; k++) begin
            if ($urandom_range(0, 15) == 0) begin
                it = IN_W'({$urandom(), $urandom()});
                it.phi_sample = PHI_W'($urandom());
                it.pad = 1'b1;
                send_request(it);
            end
            it.phi_sample = pick_phi(style < 0 ? $urandom_range(0, 6) : style);
            it.x_velocity = pick_vel(style < 0 ? $urandom_range(0, 6) : style);
            it.y_velocity = pick_vel(style < 0 ? $urandom_range(0, 6) : style);
            it.pad = 1'b0;
            send_request(it);
        end
        // non-pad requests past the grid end flush just like pads
        for (int k = 0; k < 2 * cols; k++) begin
            it = IN_W'({$urandom(), $urandom()});
            it.phi_sample = PHI_W'($urandom());
            it.pad = $urandom_range(0, 3) != 0;
            send_request(it);
        end
        grids++;
    endtask

    initial
    begin
        int n;
        cycles = 0;
        grids = 0;
        sent = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes of values, coefficients and every scheme code
        run_grid(SCH_CENTRAL, 65535, 65535, 3, 3, 2);
        run_grid(SCH_UPWIND1, 65535, 0, 3, 3, 2);
        run_grid(SCH_UPWIND2, 65535, 65535, 5, 5, 2);
        run_grid(SCH_SPARE, 0, 65535, 0, 2, 2);
        run_grid(SCH_UPWIND2, 8192, 8192, 6, 5, 4);

        // random grids, mostly small; one at the clamped largest width
        n = sent;
        while (sent - n < RANDOM_REQS) begin
            run_grid(SCH_W'($urandom_range(0, 3)),
                     $urandom_range(0, 3) == 0 ? 65535 : $urandom_range(0, 65535),
                     $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 65535),
                     $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 9),
                     $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 9),
                     $urandom_range(0, 4) == 0 ? $urandom_range(0, 4) : -1);
        end
        hold_req = 1'b1;
        run_grid(SCH_UPWIND2, $urandom_range(0, 65535), $urandom_range(0, 65535), 511, 3, -1);

        wait_drained();
        repeat (DRAIN_WAIT) @(negedge clk);
        $display("%0d grids, %0d requests sent, %0d results checked (%0d interior)",
                 grids, sent, checked, interior_seen);
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/cfs_pkg.sv
sv/cfs_ctrl.sv
sv/cfs_dp.sv
sv/convection_flux_stencil.sv
dv/convection_flux_stencil_check.sv
dv/convection_flux_stencil_test.sv
